// ===== hw/rtl/pcr_pkg.sv =====
// Shared types, constants and helper functions of the parallel comb reverb.
// No dependencies; imported by every other file of the block.
package pcr_pkg;

    localparam int NUM_COMBS = 4;
    localparam int NUM_CH    = 2;
    localparam int SMP_W     = 16;
    localparam int DLY_W     = 13;
    localparam int CH_W      = 1;
    localparam int ADDR_W    = CH_W + DLY_W;
    localparam int MIX_W     = 7;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 16;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_COMB_DELAY_0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_COMB_DELAY_1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_COMB_DELAY_2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_COMB_DELAY_3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_BASE_GAIN    = 3'd4;
    localparam logic [IDX_W-1:0] REG_MIX_PERCENT  = 3'd5;

    localparam logic [DLY_W-1:0] DELAY_RESET [NUM_COMBS] =
        '{13'd4800, 13'd4236, 13'd3881, 13'd4417};
    localparam logic signed [SMP_W-1:0] BASE_GAIN_RESET   = 16'sd3277;
    localparam logic [MIX_W-1:0]        MIX_PERCENT_RESET = 7'd1;
    localparam logic [MIX_W-1:0]        MIX_FULL          = 7'd100;

    // gain offsets 0.1313, 0.2743 and 0.31 in Q1.15
    localparam logic [13:0] GAIN_OFFSET [NUM_COMBS] =
        '{14'd0, 14'd4302, 14'd8988, 14'd10158};

    // divide by 100: bias keeps the dividend positive, reciprocal is ceil(2^33/100)
    localparam int          DIV_SHIFT = 33;
    localparam int          DIV_BIAS_Q = 1 << 18;
    localparam logic [26:0] DIV_BIAS  = 27'd26214400;
    localparam logic [26:0] DIV_RECIP = 27'd85899346;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_WR   = 6'b000100,
        S_MIX  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } pcr_state_t;

    typedef struct packed {
        logic                     rd_en;
        logic [ADDR_W-1:0]        rd_addr;
        logic                     rd_fill;
        logic                     mul_en;
        logic                     wr_en;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [SMP_W-1:0]  x;
    } pcr_comb_ctl_t;

    function automatic logic signed [SMP_W-1:0] comb_gain(
        input logic signed [SMP_W-1:0] base,
        input logic [13:0]             offset
    );
        logic signed [SMP_W:0] diff;
        diff = {base[SMP_W-1], base} - $signed({3'b000, offset});
        if (diff < -17'sd32768) begin
            return -16'sd32768;
        end
        return diff[SMP_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/pcr_comb.sv =====
// One feedback comb: delay line memory, gain multiply, rounding and write-back.
// Depends on pcr_pkg.
module pcr_comb
    import pcr_pkg::*;
(
    input  logic                    aclk,
    input  pcr_comb_ctl_t           ctl,
    input  logic signed [SMP_W-1:0] gain,
    output logic signed [SMP_W-1:0] comb_out
);

    logic signed [SMP_W-1:0] line_mem [2**ADDR_W];

    logic signed [SMP_W-1:0]   rdata_reg;
    logic                      fill_reg;
    logic signed [2*SMP_W-1:0] prod_reg;
    logic signed [SMP_W-1:0]   c_reg;

    logic signed [SMP_W-1:0]   yd;
    logic signed [2*SMP_W:0]   rnd;
    logic signed [SMP_W+1:0]   term;
    logic signed [SMP_W+1:0]   sum;
    logic signed [SMP_W-1:0]   c_next;

    always_comb begin
        yd   = fill_reg ? rdata_reg : '0;
        rnd  = {prod_reg[2*SMP_W-1], prod_reg} + 33'sd16384;
        term = rnd[2*SMP_W:SMP_W-1];
        sum  = term + {{2{ctl.x[SMP_W-1]}}, ctl.x};
        if (sum > 18'sd32767) begin
            c_next = 16'sd32767;
        end else if (sum < -18'sd32768) begin
            c_next = -16'sd32768;
        end else begin
            c_next = sum[SMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            line_mem[ctl.wr_addr] <= c_next;
        end
        if (ctl.rd_en) begin
            rdata_reg <= line_mem[ctl.rd_addr];
            fill_reg  <= ctl.rd_fill;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= gain * yd;
        end
        if (ctl.wr_en) begin
            c_reg <= c_next;
        end
    end

    assign comb_out = c_reg;

endmodule

// ===== hw/rtl/pcr_mix.sv =====
// Wet/dry mix of the four comb outputs, divide by 100 and saturation.
// Depends on pcr_pkg.
module pcr_mix
    import pcr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    mix_en,
    input  logic                    div_en,
    input  logic signed [SMP_W-1:0] comb_out [NUM_COMBS],
    input  logic signed [SMP_W-1:0] x,
    input  logic [MIX_W-1:0]        mix_percent,
    output logic signed [SMP_W-1:0] result
);

    logic signed [26:0] num_reg;
    logic [53:0]        prod_reg;

    logic signed [SMP_W+1:0] wet;
    logic [MIX_W-1:0]        mix_eff;
    logic [MIX_W-1:0]        dry_w;
    logic signed [26:0]      num_next;
    logic signed [26:0]      u;
    logic [20:0]             q;
    logic signed [21:0]      y;

    always_comb begin
        wet = '0;
        for (int k = 0; k < NUM_COMBS; k++) begin
            wet = wet + {{2{comb_out[k][SMP_W-1]}}, comb_out[k]};
        end
        mix_eff  = (mix_percent > MIX_FULL) ? MIX_FULL : mix_percent;
        dry_w    = MIX_FULL - mix_eff;
        num_next = 27'($signed({1'b0, dry_w}) * x) + 27'($signed({1'b0, mix_eff}) * wet);
        u        = num_reg + 27'sd50 + $signed(DIV_BIAS);
        q        = prod_reg[53:DIV_SHIFT];
        y        = $signed({1'b0, q}) - 22'(DIV_BIAS_Q);
        if (y > 22'sd32767) begin
            result = 16'sd32767;
        end else if (y < -22'sd32768) begin
            result = -16'sd32768;
        end else begin
            result = y[SMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mix_en) begin
            num_reg <= num_next;
        end
        if (div_en) begin
            prod_reg <= 54'(unsigned'(u)) * 54'(DIV_RECIP);
        end
    end

endmodule

// ===== hw/rtl/parallel_comb_reverb.sv =====
// Parallel comb reverb, top level: configuration registers, sequencer,
// write positions, four comb units and the mix stage. Depends on pcr_pkg,
// pcr_comb and pcr_mix.
//
// Usage:
//   s_ channel: one item per audio sample, s_tdata the signed Q1.15 sample,
//   s_tuser the channel number. m_ channel: one item per input item with the
//   mixed sample on m_tdata and the channel echoed on m_tuser.
//   Each item steps through the sequencer states: the accept cycle issues
//   the four delay line reads, then multiply, write-back, mix, reciprocal
//   divide and output load. This sequence around the single read and write
//   port of each delay line memory admits the next item only after output load.
//   The result sits in an output register; the next item is accepted while
//   it waits. If m_tready stays low the sequencer holds in its output state
//   and s_tready stays low until the register frees.
//   Reset (aresetn low, synchronous) clears the write positions and the fill
//   flags, and loads configuration defaults. The delay lines are not cleared:
//   an entry not yet written since reset reads as zero through the
//   per-channel fill tracking, so the block is ready the cycle after reset.
//   Configuration writes land on the next edge and should be made while idle.
module parallel_comb_reverb
    import pcr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [SMP_W-1:0]        s_tdata,   // [15:0] sample_in
    input  logic [CH_W-1:0]         s_tuser,   // [0] channel
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [SMP_W-1:0]        m_tdata,   // [15:0] sample_out
    output logic [CH_W-1:0]         m_tuser,   // [0] channel_out
    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata
);

    pcr_state_t state_reg, state_next;

    logic [DLY_W-1:0]        delay_reg [NUM_COMBS];
    logic signed [SMP_W-1:0] base_gain_reg;
    logic [MIX_W-1:0]        mix_percent_reg;

    logic [DLY_W-1:0]        wp_reg   [NUM_CH];
    logic                    wrap_reg [NUM_CH];

    logic signed [SMP_W-1:0] x_reg;
    logic [CH_W-1:0]         ch_reg;

    logic                    m_tvalid_reg;
    logic [SMP_W-1:0]        m_tdata_reg;
    logic [CH_W-1:0]         m_tuser_reg;

    logic                    accept;
    logic                    out_load;
    logic [DLY_W-1:0]        wp_in;
    logic [DLY_W-1:0]        rd_off   [NUM_COMBS];
    pcr_comb_ctl_t           comb_ctl [NUM_COMBS];
    logic signed [SMP_W-1:0] gain     [NUM_COMBS];
    logic signed [SMP_W-1:0] comb_out [NUM_COMBS];
    logic signed [SMP_W-1:0] mix_result;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign wp_in    = wp_reg[s_tuser];

    always_comb begin
        for (int k = 0; k < NUM_COMBS; k++) begin
            rd_off[k]           = wp_in - delay_reg[k];
            gain[k]             = comb_gain(base_gain_reg, GAIN_OFFSET[k]);
            comb_ctl[k].rd_en   = accept;
            comb_ctl[k].rd_addr = {s_tuser, rd_off[k]};
            comb_ctl[k].rd_fill = wrap_reg[s_tuser] || (rd_off[k] < wp_in);
            comb_ctl[k].mul_en  = (state_reg == S_MUL);
            comb_ctl[k].wr_en   = (state_reg == S_WR);
            comb_ctl[k].wr_addr = {ch_reg, wp_reg[ch_reg]};
            comb_ctl[k].x       = x_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_WR;
            S_WR:  state_next = S_MIX;
            S_MIX: state_next = S_DIV;
            S_DIV: state_next = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_COMBS; k++) begin
                delay_reg[k] <= DELAY_RESET[k];
            end
            base_gain_reg   <= BASE_GAIN_RESET;
            mix_percent_reg <= MIX_PERCENT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COMB_DELAY_0: delay_reg[0]    <= cfg_wdata[DLY_W-1:0];
                REG_COMB_DELAY_1: delay_reg[1]    <= cfg_wdata[DLY_W-1:0];
                REG_COMB_DELAY_2: delay_reg[2]    <= cfg_wdata[DLY_W-1:0];
                REG_COMB_DELAY_3: delay_reg[3]    <= cfg_wdata[DLY_W-1:0];
                REG_BASE_GAIN:    base_gain_reg   <= $signed(cfg_wdata[SMP_W-1:0]);
                REG_MIX_PERCENT:  mix_percent_reg <= cfg_wdata[MIX_W-1:0];
                default: ;
            endcase
        end
    end

    // write positions and fill flags, one per channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CH; c++) begin
                wp_reg[c]   <= '0;
                wrap_reg[c] <= 1'b0;
            end
        end else if (state_reg == S_WR) begin
            wp_reg[ch_reg] <= wp_reg[ch_reg] + 13'd1;
            if (wp_reg[ch_reg] == '1) begin
                wrap_reg[ch_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg  <= $signed(s_tdata);
            ch_reg <= s_tuser;
        end
        if (out_load) begin
            m_tdata_reg <= mix_result;
            m_tuser_reg <= ch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    for (genvar k = 0; k < NUM_COMBS; k++) begin : g_comb
        pcr_comb u_comb (
            .aclk     (aclk),
            .ctl      (comb_ctl[k]),
            .gain     (gain[k]),
            .comb_out (comb_out[k])
        );
    end

    pcr_mix u_mix (
        .aclk        (aclk),
        .mix_en      (state_reg == S_MIX),
        .div_en      (state_reg == S_DIV),
        .comb_out    (comb_out),
        .x           (x_reg),
        .mix_percent (mix_percent_reg),
        .result      (mix_result)
    );

    a_wp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR) |=> (wp_reg[ch_reg] == $past(wp_reg[ch_reg]) + 13'd1))
        else $error("write position did not advance by one after write-back");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

    a_wrap_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        wrap_reg[0] |=> wrap_reg[0])
        else $error("fill flag of channel 0 cleared without reset");

endmodule
